### sv/assert_macros.svh
// assertion macros for the rtl datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain condition checked at every rising clock edge outside reset
`define GCD_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// overlapping implication checked outside reset
`define GCD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

### sv/gcd_pkg.sv
`default_nettype none
package gcd_pkg;
	localparam int MAX_DIMS_DEF   = 4;
	localparam int COORD_BITS_DEF = 12;
	localparam int DIM_COUNT_W    = 3;
	localparam int SIZE_W         = 12;
	localparam int BATCH_W        = 24;
	localparam int LIN_W          = 48;
	localparam int DIMNUM_W       = 2;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 12;
	localparam int NUM_SIZE_REGS  = 4;
	localparam int DIV_W          = 26;
	localparam int DIV_STEPS      = DIV_W / 2;
	localparam int DIV_CNT_W      = 4;

	localparam logic [CFG_IDX_W-1:0] REG_DIM_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE0     = 3'd1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SMUL,
		ST_SCOMMIT,
		ST_CLAMP,
		ST_LMUL,
		ST_LACC,
		ST_EMIT,
		ST_DSTART,
		ST_DSTEP,
		ST_DCOMMIT
	} gcd_state_t;

	typedef struct packed {
		logic cfg_wr;
		logic start;
		logic clamp;
		logic mul_str;
		logic commit_str;
		logic mul_lin;
		logic acc_lin;
		logic emit;
		logic div_start;
		logic div_step;
		logic div_commit;
		logic idx_clr;
		logic idx_inc;
	} gcd_cmd_t;

	typedef struct packed {
		logic done;
		logic idx_last;
		logic idx_top;
		logic div_last;
		logic out_free;
	} gcd_stat_t;
endpackage
`default_nettype wire

### sv/grid_chunk_dispenser.sv
// grid chunk dispenser: deals out consecutive chunks of a grid of up to
// MAX_DIMS dimensions, walking a mixed-radix position.
// cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 is the
// dimension count, 1..4 the sizes; a write to one of these restarts the run,
// and after any write the block rebuilds the strides and the total.
// req channel (req_valid/req_stall): one word carries max_batch.
// res channel (res_valid/res_stall): one word per dimension in use,
// dimension 0 first, last_dim set on the top one.
// a request clamps the batch to the points left, builds the linear index
// on the shared multiplier a dimension at a time, loads one result word per
// dimension, then runs the radix-4 divider that carries the batch into
// each dimension. an exhausted grid skips the multiply and divide.
// a stalled result word holds in the output register and the next word
// waits for it; only the last word of a request can wait while the
// position update runs and the next request is taken.
// reset: one dimension of size one, position and points sent cleared.
`default_nettype none
module grid_chunk_dispenser
	import gcd_pkg::*;
#(
	parameter int MAX_DIMS   = MAX_DIMS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  req_valid,
	output logic                       req_stall,
	input  wire logic [BATCH_W-1:0]    max_batch,
	output logic                       res_valid,
	input  wire logic                  res_stall,
	output logic [DIMNUM_W-1:0]        dim_number,
	output logic [SIZE_W-1:0]          start_coord,
	output logic [BATCH_W-1:0]         batch_count,
	output logic [LIN_W-1:0]           start_linear,
	output logic                       last_dim
);
	gcd_cmd_t  cmd;
	gcd_stat_t stat;

	gcd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	gcd_dp #(
		.MAX_DIMS   (MAX_DIMS),
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.max_batch    (max_batch),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.dim_number   (dim_number),
		.start_coord  (start_coord),
		.batch_count  (batch_count),
		.start_linear (start_linear),
		.last_dim     (last_dim)
	);
endmodule
`default_nettype wire

### sv/gcd_ctrl.sv
`default_nettype none
module gcd_ctrl
	import gcd_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cfg_valid,
	output logic           cfg_ready,
	input  wire logic      req_valid,
	output logic           req_stall,
	input  wire gcd_stat_t stat,
	output gcd_cmd_t       cmd
);
	gcd_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		cfg_ready = 1'b0;
		req_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				cfg_ready = 1'b1;
				req_stall = cfg_valid;
				if (cfg_valid) begin
					cmd.cfg_wr  = 1'b1;
					cmd.idx_clr = 1'b1;
					state_d     = ST_SMUL;
				end else if (req_valid) begin
					cmd.start = 1'b1;
					state_d   = ST_CLAMP;
				end
			end
			ST_SMUL: begin
				cmd.mul_str = 1'b1;
				state_d     = ST_SCOMMIT;
			end
			ST_SCOMMIT: begin
				cmd.commit_str = 1'b1;
				if (stat.idx_top) begin
					cmd.idx_clr = 1'b1;
					state_d     = ST_IDLE;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = ST_SMUL;
				end
			end
			ST_CLAMP: begin
				cmd.clamp   = 1'b1;
				cmd.idx_clr = 1'b1;
				state_d     = ST_LMUL;
			end
			ST_LMUL: begin
				if (stat.done) begin
					state_d = ST_EMIT;
				end else begin
					cmd.mul_lin = 1'b1;
					state_d     = ST_LACC;
				end
			end
			ST_LACC: begin
				cmd.acc_lin = 1'b1;
				if (stat.idx_last) begin
					cmd.idx_clr = 1'b1;
					state_d     = ST_EMIT;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = ST_LMUL;
				end
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (stat.idx_last) begin
						cmd.idx_clr = 1'b1;
						state_d     = stat.done ? ST_IDLE : ST_DSTART;
					end else begin
						cmd.idx_inc = 1'b1;
					end
				end
			end
			ST_DSTART: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DSTEP;
			end
			ST_DSTEP: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = ST_DCOMMIT;
				end
			end
			ST_DCOMMIT: begin
				cmd.div_commit = 1'b1;
				if (stat.idx_last) begin
					cmd.idx_clr = 1'b1;
					state_d     = ST_IDLE;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = ST_DSTART;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end
endmodule
`default_nettype wire

### sv/gcd_dp.sv
`default_nettype none
`include "assert_macros.svh"
module gcd_dp
	import gcd_pkg::*;
#(
	parameter int MAX_DIMS   = MAX_DIMS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire gcd_cmd_t              cmd,
	output gcd_stat_t                  stat,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic [BATCH_W-1:0]    max_batch,
	output logic                       res_valid,
	input  wire logic                  res_stall,
	output logic [DIMNUM_W-1:0]        dim_number,
	output logic [SIZE_W-1:0]          start_coord,
	output logic [BATCH_W-1:0]         batch_count,
	output logic [LIN_W-1:0]           start_linear,
	output logic                       last_dim
);
	localparam int IDX_W   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int MUL_B_W = (COORD_BITS > SIZE_W) ? COORD_BITS : SIZE_W;
	localparam int NSZ     = (MAX_DIMS < NUM_SIZE_REGS) ? MAX_DIMS : NUM_SIZE_REGS;

	logic [DIM_COUNT_W-1:0] dim_count_q;
	logic [SIZE_W-1:0]      sizes_q  [MAX_DIMS];
	logic [SIZE_W-1:0]      eff      [MAX_DIMS];
	logic [COORD_BITS-1:0]  pos_q    [MAX_DIMS];
	logic [LIN_W-1:0]       stride_q [MAX_DIMS];
	logic [LIN_W-1:0]       total_q, sent_q;
	logic [IDX_W-1:0]       idx_q, n_last;
	logic                   out_valid_q;
	logic [DIV_CNT_W-1:0]   div_cnt_q;

	logic [BATCH_W-1:0]     req_q, count_q;
	logic [LIN_W-1:0]       prod_q, acc_q;
	logic                   done_q;
	logic [DIV_W-1:0]       carry_q, div_q_q, div_q_d;
	logic [SIZE_W-1:0]      div_r_q, div_r_d;
	logic [DIMNUM_W-1:0]    out_dim_q;
	logic [SIZE_W-1:0]      out_coord_q;
	logic [BATCH_W-1:0]     out_count_q;
	logic [LIN_W-1:0]       out_lin_q;
	logic                   out_last_q;

	logic                   cfg_hit, done_c;
	logic [LIN_W-1:0]       left_c, req_ext;
	logic [MUL_B_W-1:0]     mul_b;
	logic [SIZE_W:0]        trial;

	always_comb begin
		for (int k = 0; k < MAX_DIMS; k++) begin
			eff[k] = (sizes_q[k] == '0) ? SIZE_W'(1) : sizes_q[k];
		end
	end

	always_comb begin
		if (dim_count_q == '0) begin
			n_last = '0;
		end else if ({1'b0, dim_count_q} > (DIM_COUNT_W + 1)'(MAX_DIMS)) begin
			n_last = IDX_W'(MAX_DIMS - 1);
		end else begin
			n_last = IDX_W'(dim_count_q - 3'd1);
		end
	end

	always_comb begin
		cfg_hit = (cfg_index == REG_DIM_COUNT);
		for (int k = 0; k < NSZ; k++) begin
			if (cfg_index == CFG_IDX_W'(REG_SIZE0 + k)) begin
				cfg_hit = 1'b1;
			end
		end
	end

	assign done_c  = sent_q >= total_q;
	assign left_c  = total_q - sent_q;
	assign req_ext = LIN_W'(req_q);
	assign mul_b   = cmd.mul_str ? MUL_B_W'(eff[idx_q]) : MUL_B_W'(pos_q[idx_q]);

	// two restoring division steps a cycle
	always_comb begin
		div_r_d = div_r_q;
		div_q_d = div_q_q;
		trial   = '0;
		for (int k = 0; k < 2; k++) begin
			trial   = {div_r_d, div_q_d[DIV_W-1]};
			div_q_d = {div_q_d[DIV_W-2:0], 1'b0};
			if (trial >= {1'b0, eff[idx_q]}) begin
				trial      = trial - {1'b0, eff[idx_q]};
				div_q_d[0] = 1'b1;
			end
			div_r_d = trial[SIZE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_count_q <= DIM_COUNT_W'(1);
			for (int k = 0; k < MAX_DIMS; k++) begin
				sizes_q[k]  <= SIZE_W'(1);
				stride_q[k] <= LIN_W'(1);
				pos_q[k]    <= '0;
			end
			total_q     <= LIN_W'(1);
			sent_q      <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			div_cnt_q   <= '0;
		end else begin
			if (out_valid_q && !res_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.cfg_wr && cfg_hit) begin
				if (cfg_index == REG_DIM_COUNT) begin
					dim_count_q <= cfg_data[DIM_COUNT_W-1:0];
				end
				for (int k = 0; k < NSZ; k++) begin
					if (cfg_index == CFG_IDX_W'(REG_SIZE0 + k)) begin
						sizes_q[k] <= cfg_data[SIZE_W-1:0];
					end
				end
				for (int k = 0; k < MAX_DIMS; k++) begin
					pos_q[k] <= '0;
				end
				sent_q <= '0;
			end
			if (cmd.commit_str) begin
				if (idx_q != IDX_W'(MAX_DIMS - 1)) begin
					stride_q[IDX_W'(idx_q + 1'b1)] <= prod_q;
				end
				if (idx_q == n_last) begin
					total_q <= prod_q;
				end
			end
			if (cmd.div_start) begin
				div_cnt_q <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end
			if (cmd.div_commit) begin
				pos_q[idx_q] <= COORD_BITS'(div_r_q);
				if (idx_q == n_last) begin
					sent_q <= sent_q + LIN_W'(count_q);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			req_q <= max_batch;
		end
		if (cmd.clamp) begin
			done_q  <= done_c;
			acc_q   <= done_c ? total_q : '0;
			if (done_c) begin
				count_q <= '0;
				carry_q <= '0;
			end else if (req_ext < left_c) begin
				count_q <= req_q;
				carry_q <= DIV_W'(req_q);
			end else begin
				count_q <= left_c[BATCH_W-1:0];
				carry_q <= DIV_W'(left_c[BATCH_W-1:0]);
			end
		end
		if (cmd.mul_str || cmd.mul_lin) begin
			prod_q <= LIN_W'(stride_q[idx_q] * mul_b);
		end
		if (cmd.acc_lin) begin
			acc_q <= acc_q + prod_q;
		end
		if (cmd.emit) begin
			out_dim_q   <= DIMNUM_W'(idx_q);
			out_coord_q <= done_q ? '0 : SIZE_W'(pos_q[idx_q]);
			out_count_q <= count_q;
			out_lin_q   <= acc_q;
			out_last_q  <= (idx_q == n_last);
		end
		if (cmd.div_start) begin
			div_q_q <= DIV_W'(pos_q[idx_q]) + carry_q;
			div_r_q <= '0;
		end else if (cmd.div_step) begin
			div_q_q <= div_q_d;
			div_r_q <= div_r_d;
		end
		if (cmd.div_commit) begin
			carry_q <= div_q_q;
		end
	end

	assign stat.done     = done_q;
	assign stat.idx_last = (idx_q == n_last);
	assign stat.idx_top  = (idx_q == IDX_W'(MAX_DIMS - 1));
	assign stat.div_last = (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
	assign stat.out_free = !out_valid_q || !res_stall;

	assign res_valid    = out_valid_q;
	assign dim_number   = out_dim_q;
	assign start_coord  = out_coord_q;
	assign batch_count  = out_count_q;
	assign start_linear = out_lin_q;
	assign last_dim     = out_last_q;

	`GCD_ASSERT(a_sent_le_total, sent_q <= total_q, "points sent beyond total")
	`GCD_ASSERT_IMP(a_emit_free, cmd.emit, stat.out_free, "word loaded over a waiting word")
	`GCD_ASSERT_IMP(a_emit_idx, cmd.emit || cmd.div_commit, idx_q <= n_last,
		"dimension index past the last dimension")
	`GCD_ASSERT_IMP(a_rem_range, cmd.div_step, div_r_q < eff[idx_q],
		"remainder not below the size")
endmodule
`default_nettype wire

### dv/tb_top.sv
`default_nettype none
module tb_top;
	import gcd_pkg::*;

	typedef struct packed {
		logic [DIMNUM_W-1:0] dim;
		logic [SIZE_W-1:0]   coord;
		logic [BATCH_W-1:0]  count;
		logic [LIN_W-1:0]    linear;
		logic                last;
	} chunk_word_t;

	typedef struct {
		logic [BATCH_W-1:0] batch;
		bit                 known;
		logic [BATCH_W-1:0] count;
		logic [LIN_W-1:0]   linear;
	} dir_row_t;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam logic [CFG_IDX_W-1:0] REG_GAP    = 3'd5;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic [BATCH_W-1:0] max_batch = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	logic [DIMNUM_W-1:0] dim_number;
	logic [SIZE_W-1:0] start_coord;
	logic [BATCH_W-1:0] batch_count;
	logic [LIN_W-1:0] start_linear;
	logic last_dim;

	grid_chunk_dispenser i_dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// shadow grid state
	logic [2:0]        g_dims;
	logic [SIZE_W-1:0] g_size [4];
	logic [SIZE_W-1:0] g_pos [4];
	logic [LIN_W-1:0]  g_stride [4];
	logic [LIN_W-1:0]  g_total;
	logic [LIN_W-1:0]  g_sent;

	chunk_word_t chunk_q[$];
	chunk_word_t last_got;
	int errors = 0;
	int n_words = 0;
	int n_exhausted = 0;
	bit quiet = 1'b0;

	function automatic int dims_used();
		if (g_dims == 0) return 1;
		if (g_dims > 4) return 4;
		return int'(g_dims);
	endfunction

	function automatic logic [LIN_W-1:0] eff(int d);
		return g_size[d] == '0 ? LIN_W'(1) : LIN_W'(g_size[d]);
	endfunction

	function automatic void grid_restart();
		int n;
		n = dims_used();
		g_sent = '0;
		g_stride[0] = LIN_W'(1);
		for (int d = 0; d < 4; d++) g_pos[d] = '0;
		for (int d = 1; d < 4; d++) g_stride[d] = g_stride[d-1] * eff(d-1);
		g_total = g_stride[n-1] * eff(n-1);
	endfunction

	function automatic void grid_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
		if (idx == REG_DIM_COUNT) g_dims = v[2:0];
		else if (idx >= REG_SIZE0 && idx <= REG_SIZE0 + 3) g_size[idx - REG_SIZE0] = v;
		else return;
		grid_restart();
	endfunction

	// predict the chunk words for one request and advance the position
	function automatic void predict_chunk(logic [BATCH_W-1:0] req);
		int n;
		bit done;
		logic [LIN_W-1:0] cnt, lin, carry, sum, left;
		chunk_word_t w;
		n = dims_used();
		done = g_sent >= g_total;
		cnt = '0;
		lin = '0;
		if (done) begin
			lin = g_total;
			n_exhausted++;
		end else begin
			left = g_total - g_sent;
			cnt = LIN_W'(req) < left ? LIN_W'(req) : left;
			for (int d = 0; d < n; d++) lin = lin + LIN_W'(g_pos[d]) * g_stride[d];
		end
		for (int d = 0; d < n; d++) begin
			w.dim = DIMNUM_W'(d);
			w.coord = done ? '0 : g_pos[d];
			w.count = cnt[BATCH_W-1:0];
			w.linear = lin;
			w.last = (d == n - 1);
			chunk_q.push_back(w);
		end
		if (!done) begin
			carry = cnt;
			for (int d = 0; d < n; d++) begin
				sum = LIN_W'(g_pos[d]) + carry;
				g_pos[d] = SIZE_W'(sum % eff(d));
				carry = sum / eff(d);
			end
			g_sent = g_sent + cnt;
		end
	endfunction

	// result side
	always @(posedge clk) begin
		chunk_word_t got, exp_w;
		if (arst_n && res_valid && !res_stall) begin
			got = '{dim_number, start_coord, batch_count, start_linear, last_dim};
			last_got = got;
			n_words++;
			if (chunk_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected word %p", $time, got);
			end else begin
				exp_w = chunk_q.pop_front();
				if (got !== exp_w) begin
					errors++;
					$display("%0t: mismatch expected %p actual %p", $time, exp_w, got);
				end
			end
		end
	end

	always @(negedge clk) begin
		res_stall <= !quiet && ($urandom_range(99) < 8);
	end

	task automatic send_req(logic [BATCH_W-1:0] b);
		while (!quiet && $urandom_range(99) < 8) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		max_batch <= b;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		predict_chunk(b);
		@(negedge clk);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (chunk_q.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		grid_write(idx, v);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_grid(logic [2:0] n, logic [SIZE_W-1:0] s0, logic [SIZE_W-1:0] s1,
			logic [SIZE_W-1:0] s2, logic [SIZE_W-1:0] s3);
		drain();
		write_reg(REG_SIZE0, s0);
		write_reg(CFG_IDX_W'(REG_SIZE0 + 1), s1);
		write_reg(CFG_IDX_W'(REG_SIZE0 + 2), s2);
		write_reg(CFG_IDX_W'(REG_SIZE0 + 3), s3);
		write_reg(REG_DIM_COUNT, CFG_DATA_W'(n));
	endtask

	function automatic logic [BATCH_W-1:0] rand_batch();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return BATCH_W'($urandom());
			3, 4: return BATCH_W'($urandom_range(4095));
			default: return BATCH_W'($urandom_range(40));
		endcase
	endfunction

	dir_row_t dir_rows[] = '{
		'{24'd5, 1, 24'd1, 48'd0},
		'{24'd5, 1, 24'd0, 48'd1},
		'{24'd0, 1, 24'd0, 48'd1}
	};

	initial begin
		int left;
		g_dims = 1;
		for (int d = 0; d < 4; d++) g_size[d] = 1;
		grid_restart();
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// after reset: single point grid, then exhausted
		foreach (dir_rows[i]) begin
			send_req(dir_rows[i].batch);
			if (dir_rows[i].known) begin
				drain();
				if (last_got.count !== dir_rows[i].count ||
						last_got.linear !== dir_rows[i].linear) begin
					errors++;
					$display("%0t: row %0d expected count %0d linear %0d actual count %0d linear %0d",
						$time, i, dir_rows[i].count, dir_rows[i].linear,
						last_got.count, last_got.linear);
				end
			end
		end
		drain();
		write_reg(REG_UNUSED, 12'hfff);
		write_reg(REG_GAP, 12'h5);
		set_grid(3'd4, 12'd3, 12'd0, 12'd5, 12'd2);
		send_req(24'd0);
		send_req(24'd1);
		send_req(24'd7);
		send_req(24'hffffff);
		send_req(24'd1);
		set_grid(3'd0, 12'hfff, 12'd9, 12'd9, 12'd9);
		send_req(24'd4094);
		send_req(24'd2);
		send_req(24'd3);
		set_grid(3'd7, 12'hfff, 12'hfff, 12'hfff, 12'hfff);
		send_req(24'hffffff);
		send_req(24'h800000);
		send_req(24'h7fffff);
		send_req(24'h555555);
		send_req(24'haaaaaa);
		send_req(24'hffffff);

		// random part: small grids mostly, so they run dry now and then
		quiet = 1'b1;
		for (int k = 0; k < 60; k++) send_req(rand_batch());
		quiet = 1'b0;
		left = 390;
		while (left > 0) begin
			if ($urandom_range(3) == 0)
				set_grid(DIM_COUNT_W'($urandom_range(7)), SIZE_W'($urandom()),
					SIZE_W'($urandom()), SIZE_W'($urandom()), SIZE_W'($urandom()));
			else
				set_grid(DIM_COUNT_W'($urandom_range(7)), SIZE_W'($urandom_range(12)),
					SIZE_W'($urandom_range(12)), SIZE_W'($urandom_range(12)),
					SIZE_W'($urandom_range(12)));
			for (int k = $urandom_range(3, 20); k > 0 && left > 0; k--, left--)
				send_req(rand_batch());
		end
		drain();
		$display("covered %0d result words over ~450 requests, %0d on exhausted grids",
			n_words, n_exhausted);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("TB_ERROR");
		$finish;
	end
endmodule
`default_nettype wire

### files.f
+incdir+sv
sv/gcd_pkg.sv
sv/gcd_ctrl.sv
sv/gcd_dp.sv
sv/grid_chunk_dispenser.sv
dv/tb_top.sv
